// File: rtl/core/bsc_pkg.sv
// Shared types and constants for the barometric compensation core.
// Holds the beat structs of both channels, the calibration register map and the output limits.
// No dependencies.
`timescale 1ns / 1ps

package bsc_pkg;

    // One raw conversion pair
    typedef struct packed {
        logic [23:0] raw_pressure;
        logic [23:0] raw_temperature;
    } t_bsc_in;

    // One compensated result
    typedef struct packed {
        logic signed [14:0] temperature_centi;
        logic        [16:0] pressure_pa;
    } t_bsc_out;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Calibration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_C1 = 3'd0,   // pressure sensitivity
        CFG_C2 = 3'd1,   // pressure offset
        CFG_C3 = 3'd2,   // temperature coefficient of sensitivity
        CFG_C4 = 3'd3,   // temperature coefficient of offset
        CFG_C5 = 3'd4,   // reference temperature
        CFG_C6 = 3'd5    // temperature coefficient of temperature
    } t_cfg_idx;

    localparam int TEMP_MIN = -4000;
    localparam int TEMP_MAX = 8500;
    localparam int PRES_MIN = 1000;
    localparam int PRES_MAX = 120000;

endpackage

// File: rtl/core/baro_sensor_compensation_core.sv
// Second-order barometric pressure and temperature compensation, eleven-stage pipeline.
// Throughput: one beat per cycle while the output is not stalled; stall bubbles collapse,
// so the input keeps taking beats while any stage is empty. The low-temperature squares
// and the split pressure product each take their own stages; the wide pressure product
// is built from two 24x21 halves.
// Reset (synchronous, active low) empties the pipeline and clears all calibration words.
`timescale 1ns / 1ps

module baro_sensor_compensation_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // calibration write port
    input  logic                                i_cfg_we,
    input  logic [bsc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [bsc_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    // conversion pair in
    input  logic                                i_valid,
    output logic                                o_stall,
    input  bsc_pkg::t_bsc_in                    i_data,
    // result out
    output logic                                o_valid,
    input  logic                                i_stall,
    output bsc_pkg::t_bsc_out                   o_data
);

    localparam int unsigned StgN = 11;

    // calibration words
    logic [15:0] r_c1, r_c2, r_c3, r_c4, r_c5, r_c6;

    logic [StgN:1] r_vld;
    logic [StgN:1] w_en;

    // ---------------- stage registers ----------------
    logic        [23:0] r1_d1;
    logic signed [24:0] r1_dt;

    logic        [23:0] r2_d1;
    logic signed [40:0] r2_ptc, r2_poc, r2_psc;
    logic        [47:0] r2_pdd;

    logic        [23:0] r3_d1;
    logic signed [17:0] r3_dev;
    logic signed [41:0] r3_off1, r3_sens1;
    logic        [16:0] r3_t2;

    logic        [23:0] r4_d1;
    logic signed [17:0] r4_dev_lo, r4_dev_vl;
    logic signed [19:0] r4_temp;
    logic signed [41:0] r4_off1, r4_sens1;

    logic        [23:0] r5_d1;
    logic        [33:0] r5_sq1, r5_sq2;
    logic signed [14:0] r5_temp;
    logic signed [41:0] r5_off1, r5_sens1;

    logic        [23:0] r6_d1;
    logic        [38:0] r6_off2;
    logic        [37:0] r6_sens2;
    logic signed [14:0] r6_temp;
    logic signed [41:0] r6_off1, r6_sens1;

    logic        [23:0] r7_d1;
    logic signed [14:0] r7_temp;
    logic signed [41:0] r7_off, r7_sens;

    logic        [44:0] r8_plo;
    logic signed [44:0] r8_phi;
    logic signed [14:0] r8_temp;
    logic signed [41:0] r8_off;

    logic signed [65:0] r9_prod;
    logic signed [14:0] r9_temp;
    logic signed [41:0] r9_off;

    logic signed [45:0] r10_x;
    logic signed [14:0] r10_temp;

    logic signed [14:0] r11_temp;
    logic        [16:0] r11_pres;

    // ---------------- next values ----------------
    logic signed [24:0] n1_dt;
    logic signed [40:0] n2_ptc, n2_poc, n2_psc;
    logic signed [49:0] n2_dd;
    logic signed [40:0] n3_tc_b, n3_oc_b, n3_sc_b;
    logic signed [41:0] n3_off1, n3_sens1;
    logic               n4_low, n4_vlow;
    logic signed [17:0] n4_dev_vl;
    logic signed [19:0] n4_temp;
    logic signed [35:0] n5_sq1, n5_sq2;
    logic signed [14:0] n5_temp;
    logic        [39:0] n6_m61;
    logic        [37:0] n6_m15;
    logic        [38:0] n6_off2;
    logic        [37:0] n6_sens2;
    logic        [44:0] n8_plo;
    logic signed [44:0] n8_phi;
    logic signed [65:0] n9_prod;
    logic signed [65:0] n10_b;
    logic signed [45:0] n10_x;
    logic signed [45:0] n11_b;
    logic signed [30:0] n11_p;
    logic        [16:0] n11_pres;

    // ---------------- flow control ----------------
    // A stage advances when it is empty or the one after it advances.
    always_comb begin
        w_en[StgN] = !r_vld[StgN] || !i_stall;
        for (int k = StgN - 1; k >= 1; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_stall = !w_en[1];
    assign o_valid = r_vld[StgN];

    // ---------------- datapath ----------------
    // Stage 1: temperature deviation from the reference
    assign n1_dt = $signed({1'b0, i_data.raw_temperature}) - $signed({1'b0, r_c5, 8'b0});

    // Stage 2: first-order products
    assign n2_ptc = r1_dt * $signed({1'b0, r_c6});
    assign n2_poc = r1_dt * $signed({1'b0, r_c4});
    assign n2_psc = r1_dt * $signed({1'b0, r_c3});
    assign n2_dd  = r1_dt * r1_dt;

    // Stage 3: scale with truncation toward zero (bias negatives before the shift)
    assign n3_tc_b = r2_ptc + (r2_ptc[40] ? 41'sd8388607 : 41'sd0);
    assign n3_oc_b = r2_poc + (r2_poc[40] ? 41'sd63 : 41'sd0);
    assign n3_sc_b = r2_psc + (r2_psc[40] ? 41'sd127 : 41'sd0);
    assign n3_off1 = $signed({9'b0, r_c2, 17'b0})
                   + $signed({{7{n3_oc_b[40]}}, n3_oc_b[40:6]});
    assign n3_sens1 = $signed({10'b0, r_c1, 16'b0})
                    + $signed({{8{n3_sc_b[40]}}, n3_sc_b[40:7]});

    // Stage 4: low-temperature flags, second-order temperature
    assign n4_low    = r3_dev[17];
    assign n4_vlow   = r3_dev < -18'sd3500;
    assign n4_dev_vl = n4_vlow ? (r3_dev + 18'sd3500) : 18'sd0;
    assign n4_temp   = $signed({{2{r3_dev[17]}}, r3_dev}) + 20'sd2000
                     - (n4_low ? $signed({3'b0, r3_t2}) : 20'sd0);

    // Stage 5: squares of the deviations, temperature saturation
    assign n5_sq1 = r4_dev_lo * r4_dev_lo;
    assign n5_sq2 = r4_dev_vl * r4_dev_vl;

    always_comb begin
        if (r4_temp < 20'(bsc_pkg::TEMP_MIN)) begin
            n5_temp = 15'(bsc_pkg::TEMP_MIN);
        end else if (r4_temp > 20'(bsc_pkg::TEMP_MAX)) begin
            n5_temp = 15'(bsc_pkg::TEMP_MAX);
        end else begin
            n5_temp = r4_temp[14:0];
        end
    end

    // Stage 6: second-order offset and sensitivity terms (all non-negative)
    assign n6_m61   = {r5_sq1, 6'b0} - {4'b0, r5_sq1, 2'b0} + {6'b0, r5_sq1};
    assign n6_m15   = {r5_sq2, 4'b0} - {4'b0, r5_sq2};
    assign n6_off2  = {3'b0, n6_m61[39:4]} + {1'b0, n6_m15};
    assign n6_sens2 = {3'b0, r5_sq1, 1'b0} + {1'b0, r5_sq2, 3'b0};

    // Stage 8: pressure product split at bit 21 of the sensitivity
    assign n8_plo = r7_d1 * r7_sens[20:0];
    assign n8_phi = $signed({1'b0, r7_d1}) * $signed(r7_sens[41:21]);

    // Stage 9: recombine the halves
    assign n9_prod = $signed({r8_phi, 21'b0}) + $signed({21'b0, r8_plo});

    // Stage 10: scale down by 2^21 toward zero, remove the offset
    assign n10_b = r9_prod + (r9_prod[65] ? 66'sd2097151 : 66'sd0);
    assign n10_x = $signed({n10_b[65], n10_b[65:21]}) - $signed({{4{r9_off[41]}}, r9_off});

    // Stage 11: scale down by 2^15 toward zero, saturate
    assign n11_b = r10_x + (r10_x[45] ? 46'sd32767 : 46'sd0);
    assign n11_p = n11_b[45:15];

    always_comb begin
        if (n11_p < 31'(bsc_pkg::PRES_MIN)) begin
            n11_pres = 17'(bsc_pkg::PRES_MIN);
        end else if (n11_p > 31'(bsc_pkg::PRES_MAX)) begin
            n11_pres = 17'(bsc_pkg::PRES_MAX);
        end else begin
            n11_pres = n11_p[16:0];
        end
    end

    assign o_data.temperature_centi = r11_temp;
    assign o_data.pressure_pa       = r11_pres;

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_c1  <= '0;
            r_c2  <= '0;
            r_c3  <= '0;
            r_c4  <= '0;
            r_c5  <= '0;
            r_c6  <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    bsc_pkg::CFG_C1: r_c1 <= i_cfg_wdata;
                    bsc_pkg::CFG_C2: r_c2 <= i_cfg_wdata;
                    bsc_pkg::CFG_C3: r_c3 <= i_cfg_wdata;
                    bsc_pkg::CFG_C4: r_c4 <= i_cfg_wdata;
                    bsc_pkg::CFG_C5: r_c5 <= i_cfg_wdata;
                    bsc_pkg::CFG_C6: r_c6 <= i_cfg_wdata;
                    default: ;  // drop writes beyond the map
                endcase
            end
            if (w_en[1]) begin
                r_vld[1] <= i_valid;
            end
            for (int k = 2; k <= StgN; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_d1 <= i_data.raw_pressure;
            r1_dt <= n1_dt;
        end
        if (w_en[2]) begin
            r2_d1  <= r1_d1;
            r2_ptc <= n2_ptc;
            r2_poc <= n2_poc;
            r2_psc <= n2_psc;
            r2_pdd <= n2_dd[47:0];
        end
        if (w_en[3]) begin
            r3_d1    <= r2_d1;
            r3_dev   <= n3_tc_b[40:23];
            r3_off1  <= n3_off1;
            r3_sens1 <= n3_sens1;
            r3_t2    <= r2_pdd[47:31];
        end
        if (w_en[4]) begin
            r4_d1     <= r3_d1;
            r4_dev_lo <= n4_low ? r3_dev : 18'sd0;
            r4_dev_vl <= n4_dev_vl;
            r4_temp   <= n4_temp;
            r4_off1   <= r3_off1;
            r4_sens1  <= r3_sens1;
        end
        if (w_en[5]) begin
            r5_d1    <= r4_d1;
            r5_sq1   <= n5_sq1[33:0];
            r5_sq2   <= n5_sq2[33:0];
            r5_temp  <= n5_temp;
            r5_off1  <= r4_off1;
            r5_sens1 <= r4_sens1;
        end
        if (w_en[6]) begin
            r6_d1    <= r5_d1;
            r6_off2  <= n6_off2;
            r6_sens2 <= n6_sens2;
            r6_temp  <= r5_temp;
            r6_off1  <= r5_off1;
            r6_sens1 <= r5_sens1;
        end
        if (w_en[7]) begin
            r7_d1   <= r6_d1;
            r7_temp <= r6_temp;
            r7_off  <= r6_off1 - $signed({3'b0, r6_off2});
            r7_sens <= r6_sens1 - $signed({4'b0, r6_sens2});
        end
        if (w_en[8]) begin
            r8_plo  <= n8_plo;
            r8_phi  <= n8_phi;
            r8_temp <= r7_temp;
            r8_off  <= r7_off;
        end
        if (w_en[9]) begin
            r9_prod <= n9_prod;
            r9_temp <= r8_temp;
            r9_off  <= r8_off;
        end
        if (w_en[10]) begin
            r10_x    <= n10_x;
            r10_temp <= r9_temp;
        end
        if (w_en[11]) begin
            r11_temp <= r10_temp;
            r11_pres <= n11_pres;
        end
    end

    // ---------------- assertions ----------------
    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.temperature_centi >= 15'(bsc_pkg::TEMP_MIN))
                 && (o_data.temperature_centi <= 15'(bsc_pkg::TEMP_MAX)))
        else $error("temperature beat outside rated range");

    a_pres_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.pressure_pa >= 17'(bsc_pkg::PRES_MIN))
                 && (o_data.pressure_pa <= 17'(bsc_pkg::PRES_MAX)))
        else $error("pressure beat outside rated range");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_vld == '1) && i_stall)
        else $error("input stalled while the pipeline has a free stage");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output beat valid straight after reset");

endmodule

// File: dv/baro_comp_checker.sv
// Result checker for the barometric compensation core: watches both beat channels and the
// calibration port, predicts each result from its own copy of the calibration words.
// Depends on bsc_pkg.
`timescale 1ns / 1ps

module baro_comp_checker
    import bsc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_bsc_in               i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_bsc_out              i_out_data,
    output int                    o_mismatches,
    output int                    o_pending
);

    localparam longint TEMP_REF_CENTI  = 2000;
    localparam longint TEMP_COLD_CENTI = -1500;

    logic [15:0] c1_sens, c2_off, c3_tcs, c4_tco, c5_tref, c6_tempsens;
    t_bsc_out    compensated_q[$];
    t_bsc_out    want;

    // Divide by 2^sh, rounding the magnitude down
    function automatic longint div_pow2(input longint v, input int sh);
        if (v >= 0) begin
            return v >>> sh;
        end
        return -((-v) >>> sh);
    endfunction

    function automatic longint widen16(input logic [15:0] w);
        return longint'({48'd0, w});
    endfunction

    function automatic t_bsc_out compensate_pair(input logic [23:0] d1_raw,
                                                 input logic [23:0] d2_raw);
        longint   d1, d2, dt, temp, off, sens, t2, off2, sens2, dev, pres;
        t_bsc_out r;
        d1    = longint'({40'd0, d1_raw});
        d2    = longint'({40'd0, d2_raw});
        dt    = d2 - widen16(c5_tref) * 256;
        temp  = TEMP_REF_CENTI + div_pow2(dt * widen16(c6_tempsens), 23);
        off   = widen16(c2_off) * 131072 + div_pow2(widen16(c4_tco) * dt, 6);
        sens  = widen16(c1_sens) * 65536 + div_pow2(widen16(c3_tcs) * dt, 7);
        t2    = 0;
        off2  = 0;
        sens2 = 0;
        // second-order terms keyed on the first-order temperature
        if (temp < TEMP_REF_CENTI) begin
            dev   = temp - TEMP_REF_CENTI;
            t2    = div_pow2(dt * dt, 31);
            off2  = div_pow2(61 * dev * dev, 4);
            sens2 = 2 * dev * dev;
            if (temp < TEMP_COLD_CENTI) begin
                dev   = temp - TEMP_COLD_CENTI;
                off2  = off2 + 15 * dev * dev;
                sens2 = sens2 + 8 * dev * dev;
            end
        end
        temp = temp - t2;
        off  = off - off2;
        sens = sens - sens2;
        pres = div_pow2(div_pow2(d1 * sens, 21) - off, 15);
        if (temp < TEMP_MIN) temp = TEMP_MIN;
        if (temp > TEMP_MAX) temp = TEMP_MAX;
        if (pres < PRES_MIN) pres = PRES_MIN;
        if (pres > PRES_MAX) pres = PRES_MAX;
        r.temperature_centi = temp[14:0];
        r.pressure_pa       = pres[16:0];
        return r;
    endfunction

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            c1_sens     = '0;
            c2_off      = '0;
            c3_tcs      = '0;
            c4_tco      = '0;
            c5_tref     = '0;
            c6_tempsens = '0;
            compensated_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_C1: c1_sens     = i_cfg_wdata;
                    CFG_C2: c2_off      = i_cfg_wdata;
                    CFG_C3: c3_tcs      = i_cfg_wdata;
                    CFG_C4: c4_tco      = i_cfg_wdata;
                    CFG_C5: c5_tref     = i_cfg_wdata;
                    CFG_C6: c6_tempsens = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                compensated_q.push_back(compensate_pair(i_in_data.raw_pressure,
                                                        i_in_data.raw_temperature));
            end
            if (i_out_valid && !i_out_stall) begin
                if (compensated_q.size() == 0) begin
                    o_mismatches++;
                    $display("%0t: result beat with nothing expected, got temp %0d pres %0d",
                             $time, i_out_data.temperature_centi, i_out_data.pressure_pa);
                end else begin
                    want = compensated_q.pop_front();
                    if (i_out_data.temperature_centi !== want.temperature_centi) begin
                        o_mismatches++;
                        $display("%0t: temperature_centi expected %0d, got %0d", $time,
                                 want.temperature_centi, i_out_data.temperature_centi);
                    end
                    if (i_out_data.pressure_pa !== want.pressure_pa) begin
                        o_mismatches++;
                        $display("%0t: pressure_pa expected %0d, got %0d", $time,
                                 want.pressure_pa, i_out_data.pressure_pa);
                    end
                end
            end
        end
        o_pending = compensated_q.size();
    end

endmodule

// File: dv/baro_sensor_compensation_core_tb.sv
// Testbench top for the barometric compensation core: clock, reset, calibration phases,
// directed and random conversion pairs, random input gaps and result-side stall, verdict.
// Depends on bsc_pkg, baro_sensor_compensation_core and baro_comp_checker.
`timescale 1ns / 1ps

module baro_sensor_compensation_core_tb;
    import bsc_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PIPE_LATENCY = 11;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 3'd7;
    localparam logic [23:0] ADC_MAX = 24'hFFFFFF;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  in_valid;
    logic                  in_stall;
    t_bsc_in               in_beat;
    logic                  out_valid;
    logic                  out_stall;
    t_bsc_out              out_beat;
    int                    mismatches;
    int                    pending;
    int                    cycle_count;
    int                    stall_left;
    bit                    idling_on;
    logic [15:0]           ref_temp_word;

    baro_sensor_compensation_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_valid     (in_valid),
        .o_stall     (in_stall),
        .i_data      (in_beat),
        .o_valid     (out_valid),
        .i_stall     (out_stall),
        .o_data      (out_beat)
    );

    baro_comp_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_beat),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_beat),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side back-pressure: random bursts of stall while idling is enabled
    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_stall = 1'b1;
        end else if (idling_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 16) - 1;
            out_stall  = 1'b1;
        end else begin
            out_stall = 1'b0;
        end
    end

    // Change the idling mode away from the falling edge that the stall driver uses
    task automatic set_idling(input bit on);
        @(posedge clk);
        idling_on = on;
        @(negedge clk);
    endtask

    task automatic write_cal(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_we    = 1'b1;
        cfg_idx   = idx;
        cfg_wdata = val;
        if (idx == CFG_C5) ref_temp_word = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic load_cal(input logic [15:0] c1, input logic [15:0] c2,
                            input logic [15:0] c3, input logic [15:0] c4,
                            input logic [15:0] c5, input logic [15:0] c6);
        write_cal(CFG_C1, c1);
        write_cal(CFG_C2, c2);
        write_cal(CFG_C3, c3);
        write_cal(CFG_C4, c4);
        write_cal(CFG_C5, c5);
        write_cal(CFG_C6, c6);
    endtask

    task automatic load_typical_cal();
        load_cal(16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165);
    endtask

    task automatic load_random_cal();
        load_cal(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        // writes to indexes past the map must leave the words alone
        write_cal(CFG_UNMAPPED_LO, 16'($urandom_range(0, 65535)));
        write_cal(CFG_UNMAPPED_HI, 16'($urandom_range(0, 65535)));
    endtask

    // Called and returns at a falling edge; holds the beat until it is taken
    task automatic send_pair(input logic [23:0] d1, input logic [23:0] d2);
        if (idling_on && $urandom_range(0, 5) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        in_valid                = 1'b1;
        in_beat.raw_pressure    = d1;
        in_beat.raw_temperature = d2;
        do begin
            @(posedge clk);
        end while (in_stall);
        @(negedge clk);
    endtask

    // Raw temperature at a signed offset from the programmed reference, kept in ADC range
    function automatic logic [23:0] d2_at(input int offset);
        longint v;
        v = longint'(ref_temp_word) * 256 + offset;
        if (v < 0) v = 0;
        if (v > longint'(ADC_MAX)) v = longint'(ADC_MAX);
        return v[23:0];
    endfunction

    task automatic drain();
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (PIPE_LATENCY + 4) @(negedge clk);
    endtask

    task automatic send_random_pairs(input int count);
        int          kind;
        logic [23:0] d1, d2;
        repeat (count) begin
            kind = int'($urandom_range(0, 9));
            if (kind < 6) begin
                // realistic conversions: cold through hot around the reference
                d1 = 24'($urandom_range(2000000, 12000000));
                d2 = d2_at(int'($urandom_range(0, 6000000)) - 3500000);
            end else if (kind < 8) begin
                d1 = 24'($urandom_range(0, 16777215));
                d2 = d2_at(int'($urandom_range(0, 8192)) - 4096);
            end else begin
                d1 = 24'($urandom_range(0, 16777215));
                d2 = 24'($urandom_range(0, 16777215));
            end
            send_pair(d1, d2);
        end
    endtask

    initial begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = CFG_C1;
        cfg_wdata     = '0;
        in_valid      = 1'b0;
        in_beat       = '0;
        out_stall     = 1'b0;
        stall_left    = 0;
        idling_on     = 1'b0;
        cycle_count   = 0;
        ref_temp_word = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // unprogrammed calibration words
        send_pair(24'd0, 24'd0);
        send_pair(ADC_MAX, ADC_MAX);
        send_pair(24'h800000, 24'h7FFFFF);
        drain();

        // datasheet-like calibration: thresholds, corrections and clamps
        set_idling(1'b1);
        load_typical_cal();
        send_pair(24'd6465444, 24'd8077636);
        send_pair(24'd6465444, d2_at(0));
        send_pair(24'd6465444, d2_at(-1));
        send_pair(24'd6465444, d2_at(-297));
        send_pair(24'd6465444, d2_at(-298));
        send_pair(24'd6465444, d2_at(-1042000));
        send_pair(24'd6465444, d2_at(-1043000));
        send_pair(24'd6465444, d2_at(-3000000));
        send_pair(24'd6465444, d2_at(2500000));
        send_pair(24'd0, d2_at(0));
        send_pair(ADC_MAX, d2_at(0));
        send_pair(24'd6465444, 24'd0);
        send_pair(24'd6465444, ADC_MAX);
        drain();

        // every word at its top value, then explicitly back to zero
        load_cal(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pair(ADC_MAX, 24'd0);
        send_pair(ADC_MAX, ADC_MAX);
        send_pair(24'd0, ADC_MAX);
        send_pair(24'd1, d2_at(0));
        drain();
        load_cal(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_pair(ADC_MAX, 24'd12345);
        drain();

        load_random_cal();
        send_random_pairs(300);
        drain();

        set_idling(1'b0);
        load_random_cal();
        send_random_pairs(300);
        drain();

        set_idling(1'b1);
        load_typical_cal();
        send_random_pairs(300);
        drain();

        load_random_cal();
        send_random_pairs(200);
        drain();

        // closing stretch at full rate
        set_idling(1'b0);
        load_typical_cal();
        send_random_pairs(200);
        drain();

        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: baro_sensor_compensation_core.f
rtl/core/bsc_pkg.sv
rtl/core/baro_sensor_compensation_core.sv
dv/baro_comp_checker.sv
dv/baro_sensor_compensation_core_tb.sv
